>>> design/ffra_pkg.sv
// Package for the first-fit region allocator.
// Holds table sizes, command and status codes and the region entry type.
// Has no dependencies.
package ffra_pkg;

  localparam int MAX_REGIONS  = 64;
  localparam int IDX_W        = $clog2(MAX_REGIONS);
  localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
  localparam int HEADER_BYTES = 56;
  localparam int MIN_BLOCK    = 32;
  localparam int IN_W         = 72;
  localparam int OUT_W        = 104;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        used;
  } region_t;

endpackage

>>> design/first_fit_region_allocator_top.sv
// Top level of the first-fit region allocator with coalescing.
// Holds the sequencer, the region table memory and the result register; uses ffra_pkg.
// Depends on ffra_pkg only.
//
// Commands are taken one at a time. A sequencer walks the address-ordered
// region table, a memory of 64 entries with one read and one write port,
// reading and checking each entry searched, and reading and writing each
// entry moved when a region is inserted or removed. The work of an allocate
// or free is set by the number of table entries searched and shifted; a
// resize that moves the block searches the table three times. After reset or
// a configuration write the table is rebuilt as one free region. A finished
// result waits in the output register while the next beat is worked on.
module first_fit_region_allocator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [31:0]               cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // cmd[1:0], block_address[33:2], req_length[65:34], req_align_log2[69:66]
  input  logic [ffra_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // result_address[31:0], status[33:32], moved[34], old_address[66:35],
  // old_length[98:67]
  output logic [ffra_pkg::OUT_W-1:0] out_tdata
);
  import ffra_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CK, S_SP0, S_SP1, S_SP2, S_SP3,
    S_INS, S_INSW, S_SPW, S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5,
    S_RM, S_RMW, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_ALLOC, PH_FREE, PH_RESIZE, PH_RALLOC, PH_RFIND
  } phase_t;

  localparam logic [31:0] HDR   = 32'(HEADER_BYTES);
  localparam logic [33:0] BMASK = 34'(MIN_BLOCK - 1);
  localparam logic [3:0]  AL_MIN = 4'd4;

  region_t mem [MAX_REGIONS];
  region_t rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  region_t           mem_wd;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  region_t ent_r, ent_nxt;
  logic [31:0] addr_r, addr_nxt, len_r, len_nxt;
  logic [3:0]  al_r, al_nxt;
  logic        find_r, find_nxt;
  logic [33:0] off_r, off_nxt;
  logic [31:0] na_r, na_nxt, new_s_r, new_s_nxt, new_l_r, new_l_nxt;
  logic        prev_free_r, prev_free_nxt, next_free_r, next_free_nxt;
  logic [31:0] prev_start_r, prev_start_nxt, prev_len_r, prev_len_nxt;
  logic [31:0] next_len_r, next_len_nxt, acc_r, acc_nxt, old_len_r, old_len_nxt;
  logic [1:0]  dsh_r, dsh_nxt;
  logic [31:0] res_r, res_nxt, oa_r, oa_nxt, ol_r, ol_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        mv_r, mv_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [31:0] base_r, base_nxt, plen_r, plen_nxt;

  logic [3:0]  in_al;
  logic [33:0] off_rnd;
  logic [31:0] pad, amask, acc_sum;
  logic [CNT_W-1:0] i_ext;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign in_tready  = (state_r == S_IDLE) && !cfg_we;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_al      = (in_tdata[69:66] < AL_MIN) ? AL_MIN : in_tdata[69:66];
  assign i_ext      = {1'b0, i_r};
  assign off_rnd    = ({2'b0, len_r} + BMASK) & ~BMASK;
  assign amask      = (32'd1 << al_r) - 32'd1;
  assign pad        = (~na_r + 32'd1) & amask;
  assign acc_sum    = prev_len_r + HDR + ent_r.len;

  always_comb begin
    state_nxt = state_r;  ph_nxt = ph_r;  cnt_nxt = cnt_r;  idx_nxt = idx_r;
    i_nxt = i_r;  ent_nxt = ent_r;  addr_nxt = addr_r;
    len_nxt = len_r;  al_nxt = al_r;  find_nxt = find_r;  off_nxt = off_r;
    na_nxt = na_r;  new_s_nxt = new_s_r;  new_l_nxt = new_l_r;
    prev_free_nxt = prev_free_r;  next_free_nxt = next_free_r;
    prev_start_nxt = prev_start_r;  prev_len_nxt = prev_len_r;
    next_len_nxt = next_len_r;  acc_nxt = acc_r;  old_len_nxt = old_len_r;
    dsh_nxt = dsh_r;  res_nxt = res_r;  st_nxt = st_r;  mv_nxt = mv_r;
    oa_nxt = oa_r;  ol_nxt = ol_r;  out_data_nxt = out_data_r;
    base_nxt = base_r;  plen_nxt = plen_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;

    case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd.start = base_r;
        mem_wd.len   = (plen_r >= HDR) ? plen_r - HDR : 32'd0;
        mem_wd.used  = 1'b0;
        cnt_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          addr_nxt = in_tdata[33:2];
          len_nxt  = in_tdata[65:34];
          al_nxt   = (in_tdata[1:0] == CMD_ALLOC) ? in_al : AL_MIN;
          res_nxt = '0;  st_nxt = ST_OK;  mv_nxt = 1'b0;  oa_nxt = '0;  ol_nxt = '0;
          idx_nxt = '0;
          state_nxt = S_SCAN_RD;
          if (in_tdata[1:0] == CMD_ALLOC ||
              (in_tdata[1:0] == CMD_RESIZE && in_tdata[33:2] == 32'd0)) begin
            ph_nxt = PH_ALLOC;  find_nxt = 1'b0;
          end else if (in_tdata[1:0] == CMD_FREE && in_tdata[33:2] != 32'd0) begin
            ph_nxt = PH_FREE;  find_nxt = 1'b1;
          end else if (in_tdata[1:0] == CMD_RESIZE) begin
            ph_nxt = PH_RESIZE;  find_nxt = 1'b1;
          end else begin
            st_nxt = ST_NULL;
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN_RD: begin
        mem_ra = idx_r[IDX_W-1:0];
        if (idx_r >= cnt_r) begin
          case (ph_r)
            PH_ALLOC, PH_RALLOC: begin
              st_nxt = ST_NO_FREE;
              state_nxt = S_DONE;
            end
            PH_RFIND: begin
              mv_nxt = 1'b1;  oa_nxt = addr_r;  ol_nxt = old_len_r;
              state_nxt = S_DONE;
            end
            default: begin
              st_nxt = ST_BAD;
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        state_nxt = S_SCAN_RD;
        idx_nxt = idx_r + CNT_W'(1);
        ent_nxt = rd_q;
        i_nxt = idx_r[IDX_W-1:0];
        if (find_r) begin
          if (rd_q.start + HDR == addr_r) begin
            if (!rd_q.used) begin
              idx_nxt = cnt_r;
            end else if (ph_r == PH_FREE || ph_r == PH_RFIND) begin
              state_nxt = S_FR0;
            end else if (len_r < rd_q.len) begin
              state_nxt = S_SP0;
            end else begin
              old_len_nxt = rd_q.len;
              ph_nxt = PH_RALLOC;
              find_nxt = 1'b0;
              idx_nxt = '0;
            end
          end
        end else if (!rd_q.used && rd_q.len >= len_r) begin
          state_nxt = S_SP0;
        end
      end
      S_SP0: begin
        off_nxt = off_rnd;
        na_nxt = ent_r.start + HDR + HDR + off_rnd[31:0];
        state_nxt = (cnt_r == CNT_W'(MAX_REGIONS)) ? S_SPW : S_SP1;
      end
      S_SP1: begin
        off_nxt = off_r + {2'b0, pad};
        state_nxt = S_SP2;
      end
      S_SP2: begin
        if ({2'b0, ent_r.len} < off_r ||
            ent_r.len - off_r[31:0] < HDR + 32'(MIN_BLOCK)) begin
          state_nxt = S_SPW;
        end else begin
          new_s_nxt = ent_r.start + HDR + off_r[31:0];
          new_l_nxt = ent_r.len - off_r[31:0] - HDR;
          ent_nxt.len = off_r[31:0];
          idx_nxt = cnt_r;
          if (i_ext + CNT_W'(1) < cnt_r) begin
            mem_ra = i_r + IDX_W'(1);
            state_nxt = S_SP3;
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_SP3: begin
        if (!rd_q.used) begin
          mem_we = 1'b1;
          mem_wa = i_r + IDX_W'(1);
          mem_wd.start = new_s_r;
          mem_wd.len   = new_l_r + HDR + rd_q.len;
          mem_wd.used  = 1'b0;
          state_nxt = S_SPW;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (idx_r == i_ext + CNT_W'(1)) begin
          mem_we = 1'b1;
          mem_wa = idx_r[IDX_W-1:0];
          mem_wd.start = new_s_r;
          mem_wd.len   = new_l_r;
          mem_wd.used  = 1'b0;
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_SPW;
        end else begin
          mem_ra = idx_r[IDX_W-1:0] - IDX_W'(1);
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        mem_we = 1'b1;
        mem_wa = idx_r[IDX_W-1:0];
        mem_wd = rd_q;
        idx_nxt = idx_r - CNT_W'(1);
        state_nxt = S_INS;
      end
      S_SPW: begin
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd.start = ent_r.start;
        mem_wd.len   = ent_r.len;
        mem_wd.used  = 1'b1;
        state_nxt = S_DONE;
        if (ph_r == PH_RESIZE) begin
          res_nxt = addr_r;
        end else begin
          res_nxt = ent_r.start + HDR;
        end
        if (ph_r == PH_RALLOC) begin
          ph_nxt = PH_RFIND;
          find_nxt = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FR0: begin
        prev_free_nxt = 1'b0;
        next_free_nxt = 1'b0;
        mem_ra = i_r - IDX_W'(1);
        state_nxt = (i_r != '0) ? S_FR1 : S_FR2;
      end
      S_FR1: begin
        prev_free_nxt = !rd_q.used;
        prev_start_nxt = rd_q.start;
        prev_len_nxt = rd_q.len;
        state_nxt = S_FR2;
      end
      S_FR2: begin
        mem_ra = i_r + IDX_W'(1);
        state_nxt = (i_ext + CNT_W'(1) < cnt_r) ? S_FR3 : S_FR4;
      end
      S_FR3: begin
        next_free_nxt = !rd_q.used;
        next_len_nxt = rd_q.len;
        state_nxt = S_FR4;
      end
      S_FR4: begin
        acc_nxt = prev_free_r ? acc_sum : ent_r.len;
        state_nxt = S_FR5;
      end
      S_FR5: begin
        mem_we = 1'b1;
        mem_wa = prev_free_r ? i_r - IDX_W'(1) : i_r;
        mem_wd.start = prev_free_r ? prev_start_r : ent_r.start;
        mem_wd.len   = next_free_r ? acc_r + HDR + next_len_r : acc_r;
        mem_wd.used  = 1'b0;
        dsh_nxt = {1'b0, prev_free_r} + {1'b0, next_free_r};
        idx_nxt = prev_free_r ? i_ext : i_ext + CNT_W'(1);
        state_nxt = (prev_free_r || next_free_r) ? S_RM : S_DONE;
        if (ph_r == PH_RFIND) begin
          mv_nxt = 1'b1;  oa_nxt = addr_r;  ol_nxt = old_len_r;
        end
      end
      S_RM: begin
        mem_ra = idx_r[IDX_W-1:0] + IDX_W'(dsh_r);
        if (idx_r + CNT_W'(dsh_r) >= cnt_r) begin
          cnt_nxt = cnt_r - CNT_W'(dsh_r);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        mem_we = 1'b1;
        mem_wa = idx_r[IDX_W-1:0];
        mem_wd = rd_q;
        idx_nxt = idx_r + CNT_W'(1);
        state_nxt = S_RM;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {5'b0, ol_r, oa_r, mv_r, st_r, res_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (cfg_we) begin
      if (cfg_addr == CFG_BASE) begin
        base_nxt = cfg_wdata;
      end else begin
        plen_nxt = cfg_wdata;
      end
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ph_r <= PH_ALLOC;
      cnt_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
      base_r <= '0;
      plen_r <= 32'd65536;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      base_r <= base_nxt;
      plen_r <= plen_nxt;
    end
    idx_r <= idx_nxt;  i_r <= i_nxt;  ent_r <= ent_nxt;
    addr_r <= addr_nxt;  len_r <= len_nxt;  al_r <= al_nxt;  find_r <= find_nxt;
    off_r <= off_nxt;  na_r <= na_nxt;  new_s_r <= new_s_nxt;  new_l_r <= new_l_nxt;
    prev_free_r <= prev_free_nxt;  next_free_r <= next_free_nxt;
    prev_start_r <= prev_start_nxt;  prev_len_r <= prev_len_nxt;
    next_len_r <= next_len_nxt;  acc_r <= acc_nxt;  old_len_r <= old_len_nxt;
    dsh_r <= dsh_nxt;  res_r <= res_nxt;  st_r <= st_nxt;  mv_r <= mv_nxt;
    oa_r <= oa_nxt;  ol_r <= ol_nxt;  out_data_r <= out_data_nxt;
  end

endmodule
